// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/cbf_pkg.sv
package cbf_pkg;
  localparam int MaxSize = 1024;
  localparam int ChBits = 16;
  localparam int IdxW = $clog2(MaxSize);
  localparam int SizeW = 11;
  localparam int SumW = ChBits + 4;
  // reciprocals rounded up; the extra shift bits keep the quotient exact
  // for every SumW-bit sum
  localparam int RecipShift = SumW + 4;
  localparam int Recip3 = ((1 << RecipShift) + 2) / 3;
  localparam int Recip9 = ((1 << RecipShift) + 8) / 9;

  typedef struct packed {
    logic [ChBits-1:0] b;
    logic [ChBits-1:0] g;
    logic [ChBits-1:0] r;
  } pix_t;

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            last;
    logic [1:0]      r0;
    logic [1:0]      c0;
  } job_t;

  // sum / cnt for cnt in {1,2,3,4,6,9}; reciprocal multiply, /6 as /2 then /3
  function automatic logic [ChBits-1:0] div_cnt(input logic [SumW-1:0] s,
                                                input logic [3:0] cnt);
    logic [SumW+RecipShift-1:0] p;
    logic [SumW-1:0]            q;
    p = '0;
    q = '0;
    unique case (cnt)
      4'd1: q = s;
      4'd2: q = s >> 1;
      4'd4: q = s >> 2;
      4'd3: begin
        p = (SumW+RecipShift)'(s) * (SumW+RecipShift)'(Recip3);
        q = SumW'(p >> RecipShift);
      end
      4'd6: begin
        p = (SumW+RecipShift)'(s >> 1) * (SumW+RecipShift)'(Recip3);
        q = SumW'(p >> RecipShift);
      end
      4'd9: begin
        p = (SumW+RecipShift)'(s) * (SumW+RecipShift)'(Recip9);
        q = SumW'(p >> RecipShift);
      end
      default: q = s;
    endcase
    return q[ChBits-1:0];
  endfunction
endpackage

// File: sv/cbf_lines.sv
module cbf_lines import cbf_pkg::*; (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output pix_t            rd_older,
  output pix_t            rd_newer,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  pix_t            wr_older,
  input  pix_t            wr_newer
);
  pix_t mem_o [MaxSize];
  pix_t mem_n [MaxSize];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_o[wr_addr] <= wr_older;
      mem_n[wr_addr] <= wr_newer;
    end
    if (rd_en) begin
      rd_older <= mem_o[rd_addr];
      rd_newer <= mem_n[rd_addr];
    end
  end
endmodule

// File: sv/cbf_emit.sv
module cbf_emit import cbf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  job_t          job,
  input  pix_t          win [9],
  output logic          busy,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata,
  output logic          out_tlast
);
  // walks the result list of one pixel: r0 = 0..rmax, c0 = 0..cmax
  logic       busy_r, busy_nxt;
  logic [1:0] r0_r, r0_nxt, c0_r, c0_nxt, rmax_r, cmax_r;
  logic [IdxW-1:0] row_r, col_r;
  logic       vld_r, vld_nxt;
  logic [71:0] dat_r, dat_nxt;
  logic       lst_r, lst_nxt;
  logic [SumW-1:0] sr, sg, sb;
  logic [3:0] cnt;
  logic       take;

  always_comb begin
    sr = '0; sg = '0; sb = '0;
    for (int i = 0; i < 9; i++) begin
      if (2'(i / 3) >= r0_r && 2'(i % 3) >= c0_r) begin
        sr = sr + SumW'(win[i].r);
        sg = sg + SumW'(win[i].g);
        sb = sb + SumW'(win[i].b);
      end
    end
    cnt = 4'((3 - r0_r) * (3 - c0_r));
  end

  assign take = busy_r && (!vld_r || out_tready);

  always_comb begin
    busy_nxt = busy_r;
    r0_nxt = r0_r;
    c0_nxt = c0_r;
    vld_nxt = vld_r && !out_tready;
    dat_nxt = dat_r;
    lst_nxt = lst_r;
    if (take) begin
      vld_nxt = 1'b1;
      dat_nxt = {4'd0, IdxW'(col_r + IdxW'(c0_r)), IdxW'(row_r + IdxW'(r0_r)),
                 div_cnt(sb, cnt), div_cnt(sg, cnt), div_cnt(sr, cnt)};
      lst_nxt = (r0_r == rmax_r) && (c0_r == cmax_r);
      if (c0_r == cmax_r) begin
        c0_nxt = '0;
        if (r0_r == rmax_r) busy_nxt = 1'b0;
        else r0_nxt = r0_r + 2'd1;
      end else begin
        c0_nxt = c0_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      busy_r <= start ? 1'b1 : busy_nxt;
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
    lst_r <= lst_nxt;
    if (start) begin
      r0_r <= '0;
      c0_r <= '0;
      rmax_r <= job.r0;
      cmax_r <= job.c0;
      row_r <= job.row;
      col_r <= job.col;
    end else begin
      r0_r <= r0_nxt;
      c0_r <= c0_nxt;
    end
  end

  assign busy = busy_r;
  assign out_tvalid = vld_r;
  assign out_tdata = dat_r;
  assign out_tlast = lst_r;

`include "assert_macros.svh"
  `ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy_r)
  `ASSERT_IMPL(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_IMPL(a_cnt, clk, rst_n, busy_r |-> cnt != 4'd0)
endmodule

// File: sv/clipped_box_filter_3x3.sv
// Streaming 3x3 box filter, clipped at the bottom and right edges, over a
// square RGB image of cfg size (3..1024, clamped) in raster order. Each
// pixel is read from the line stores when it is accepted (registered RAM
// output), then the update state shifts the window and writes the stores
// back. A pixel that causes k results (0..9) holds off the input while the
// shared averaging unit emits them, one result per cycle when the output is
// not stalled. Writing cfg_wdata restarts the frame at row 0, column 0.
module clipped_box_filter_3x3 import cbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // in_red, in_green, in_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_red, out_green, out_blue, out_row, out_col
  output logic        out_tlast   // last_of_run
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic            st_r;
  logic [IdxW:0]   n_r;
  logic [IdxW-1:0] x_r, y_r;
  pix_t            cur_r;
  pix_t            win_r [9];
  pix_t            ro, rn;
  logic            acc, busy, start;
  job_t            job;
  logic [IdxW:0]   nm1;

  assign in_tready = (st_r == ST_IDLE) && !busy;
  assign acc = in_tvalid && in_tready;
  assign nm1 = n_r - 1'b1;

  cbf_lines u_lines (
    .clk(clk), .rd_en(acc), .rd_addr(x_r), .rd_older(ro), .rd_newer(rn),
    .wr_en(st_r == ST_UPD), .wr_addr(x_r), .wr_older(rn), .wr_newer(cur_r)
  );

  assign start = (st_r == ST_UPD) && y_r >= IdxW'(2) && x_r >= IdxW'(2);
  always_comb begin
    job.row = y_r - IdxW'(2);
    job.col = x_r - IdxW'(2);
    job.last = 1'b0;
    job.r0 = ({1'b0, y_r} == nm1) ? 2'd2 : 2'd0;
    job.c0 = ({1'b0, x_r} == nm1) ? 2'd2 : 2'd0;
  end

  cbf_emit u_emit (
    .clk(clk), .rst_n(rst_n), .start(start), .job(job), .win(win_r),
    .busy(busy), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      n_r <= (IdxW+1)'(MaxSize);
      x_r <= '0;
      y_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata < 11'd3) n_r <= (IdxW+1)'(3);
        else if (cfg_wdata > 11'(MaxSize)) n_r <= (IdxW+1)'(MaxSize);
        else n_r <= (IdxW+1)'(cfg_wdata);
        x_r <= '0;
        y_r <= '0;
      end
      unique case (st_r)
        ST_IDLE: if (acc) st_r <= ST_UPD;
        ST_UPD: begin
          st_r <= ST_IDLE;
          for (int r = 0; r < 3; r++) begin
            win_r[r*3] <= win_r[r*3+1];
            win_r[r*3+1] <= win_r[r*3+2];
          end
          win_r[2] <= ro;
          win_r[5] <= rn;
          win_r[8] <= cur_r;
          if (!cfg_we) begin
            if ({1'b0, x_r} == nm1) begin
              x_r <= '0;
              y_r <= ({1'b0, y_r} == nm1) ? '0 : y_r + 1'b1;
            end else begin
              x_r <= x_r + 1'b1;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
    if (acc) cur_r <= in_tdata;
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_upd, clk, rst_n, acc |=> st_r == ST_UPD)
  `ASSERT_NEVER(a_xrange, clk, rst_n, {1'b0, x_r} >= n_r)
  `ASSERT_IMPL(a_start, clk, rst_n, start |=> busy)
endmodule

// File: sim/tb_top.sv
module tb_top;
  import cbf_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles = 30;
  localparam int LongHold = 300;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } avg_pix_t;

  class box_avg_board;
    logic [47:0]  older_line[MaxSize];
    logic [47:0]  newer_line[MaxSize];
    logic [47:0]  win[9];
    int unsigned  size;
    int unsigned  row_pos;
    int unsigned  col_pos;
    avg_pix_t     avg_q[$];
    int           errors;
    int           n_pix;
    int           n_avg;

    function new();
      size = MaxSize;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      n_pix = 0;
      n_avg = 0;
      foreach (win[i]) win[i] = '0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
    endfunction

    function void set_size(logic [10:0] v);
      if (v < 3) size = 3;
      else if (v > MaxSize) size = MaxSize;
      else size = v;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int pending();
      return avg_q.size();
    endfunction

    // average over window rows r0..2 and cols c0..2
    function avg_pix_t window_avg(int r0, int c0);
      avg_pix_t a;
      int unsigned sr, sg, sb, cnt;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int r = r0; r < 3; r++)
        for (int c = c0; c < 3; c++) begin
          sr += win[r*3+c][15:0];
          sg += win[r*3+c][31:16];
          sb += win[r*3+c][47:32];
        end
      cnt = (3 - r0) * (3 - c0);
      a.red = 16'(sr / cnt);
      a.green = 16'(sg / cnt);
      a.blue = 16'(sb / cnt);
      a.row = 10'(row_pos - 2 + r0);
      a.col = 10'(col_pos - 2 + c0);
      a.last = 1'b0;
      return a;
    endfunction

    function void note_pixel(logic [47:0] px);
      int unsigned xi, rlast, clast;
      avg_pix_t a;
      xi = col_pos % MaxSize;
      n_pix++;
      for (int r = 0; r < 3; r++) begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = older_line[xi];
      win[5] = newer_line[xi];
      win[8] = px;
      older_line[xi] = newer_line[xi];
      newer_line[xi] = px;
      if (row_pos >= 2 && col_pos >= 2) begin
        rlast = (row_pos == size - 1) ? 2 : 0;
        clast = (col_pos == size - 1) ? 2 : 0;
        for (int r0 = 0; r0 <= rlast; r0++)
          for (int c0 = 0; c0 <= clast; c0++) begin
            a = window_avg(r0, c0);
            a.last = (r0 == rlast && c0 == clast);
            avg_q.push_back(a);
          end
      end
      col_pos++;
      if (col_pos >= size) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= size) row_pos = 0;
      end
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_word(logic [71:0] d, logic last);
      avg_pix_t e;
      if (avg_q.size() == 0) begin
        report("unexpected word, row", d[57:48], -1);
        return;
      end
      e = avg_q.pop_front();
      n_avg++;
      if (d[15:0] !== e.red) report("red", d[15:0], e.red);
      if (d[31:16] !== e.green) report("green", d[31:16], e.green);
      if (d[47:32] !== e.blue) report("blue", d[47:32], e.blue);
      if (d[57:48] !== e.row) report("row", d[57:48], e.row);
      if (d[67:58] !== e.col) report("col", d[67:58], e.col);
      if (last !== e.last) report("tlast", last, e.last);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;

  box_avg_board board;
  bit idle_on;
  bit long_hold;
  int frames;
  int quiet_cycles;

  clipped_box_filter_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_pixel(in_tdata);
      if (out_tvalid && out_tready) board.check_word(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("clipped_box_filter_3x3 test failed");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 0;
        stall_left = LongHold - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task send_pixel(logic [47:0] px);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  task write_size(logic [10:0] v);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_size(v);
    frames++;
  endtask

  function logic [15:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [47:0] rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  initial begin
    int total, n, cnt;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_on = 0;
    long_hold = 0;
    frames = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: a few words in row 0, nothing comes out
    send_pixel('0);
    send_pixel({48{1'b1}});
    send_pixel({24{2'b01}});
    send_pixel({24{2'b10}});
    // size below range clamps to 3; frame of full-scale words
    write_size(11'd0);
    repeat (9) send_pixel({48{1'b1}});
    // size above range clamps to the maximum, then restart mid-frame
    write_size(11'h7ff);
    repeat (3) send_pixel(rand_pixel());
    write_size(11'd3);
    // receiver holds off while two frames are offered; the corner burst
    // of the first frame backs up into the input
    long_hold = 1;
    for (int i = 0; i < 18; i++) send_pixel({16'd1 + 16'(i), 16'd0, 16'hffff - 16'(i)});
    total = 34;

    // random frames
    idle_on = 1;
    while (total < 470) begin
      idle_on = (total < 400);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(3, 8);
      if ($urandom_range(0, 9) == 0) write_size(11'($urandom_range(0, 2)));
      else write_size(11'(n));
      n = board.size;
      case ($urandom_range(0, 4))
        0: cnt = $urandom_range(1, n * n - 1);
        1: cnt = 2 * n * n;
        default: cnt = n * n;
      endcase
      if (cnt > 470 - total) cnt = 470 - total;
      for (int i = 0; i < cnt; i++) send_pixel(rand_pixel());
      total += cnt;
    end
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d pixels over %0d size settings (3..12, clamped extremes)",
             board.n_pix, frames);
    $display("checked %0d averaged words incl. edge and corner windows", board.n_avg);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("clipped_box_filter_3x3 test passed");
    end else begin
      $display("clipped_box_filter_3x3 test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/cbf_pkg.sv
sv/cbf_lines.sv
sv/cbf_emit.sv
sv/clipped_box_filter_3x3.sv
sim/tb_top.sv
